// File: rtl/sst_pkg.sv
// Shared types, constants and command codes for the sort and search table.
package sst_pkg;

  localparam int unsigned Depth     = 256;
  localparam int unsigned AddrBits  = 8;
  localparam int unsigned CountBits = 9;
  localparam int unsigned ValueBits = 10;
  localparam int unsigned StepBits  = 15;
  localparam logic [StepBits-1:0] StepMax = 15'h7FFF;

  typedef enum logic [2:0] {
    CMD_LOAD   = 3'd0,
    CMD_SORT   = 3'd1,
    CMD_SLIN   = 3'd2,
    CMD_LLIN   = 3'd3,
    CMD_BIN    = 3'd4,
    CMD_READ   = 3'd5
  } cmd_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_RANGE     = 2'd2
  } status_e;

  // Controller to datapath commands.
  typedef struct packed {
    logic                 wr_both;   // load: write working copy at addr and load-order copy at laddr
    logic                 wr_work;   // write working copy at addr
    logic [AddrBits-1:0]  addr;      // working copy address
    logic [AddrBits-1:0]  laddr;     // load-order copy address
    logic [ValueBits-1:0] wdata;
  } dp_cmd_t;

  // Datapath to controller status: registered read data.
  typedef struct packed {
    logic [ValueBits-1:0] wrd;
    logic [ValueBits-1:0] lrd;
  } dp_sts_t;

endpackage

// File: rtl/sst_datapath.sv
// Table datapath: working and load-order copies with registered reads.
module sst_datapath import sst_pkg::*; (
  input  logic    clk_i,
  input  dp_cmd_t cmd_i,
  output dp_sts_t sts_o
);

  logic [ValueBits-1:0] work_mem [Depth];
  logic [ValueBits-1:0] load_mem [Depth];
  logic [ValueBits-1:0] wrd_q, lrd_q;

  // Working copy: one write port and one registered read port.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_both || cmd_i.wr_work) begin
      work_mem[cmd_i.addr] <= cmd_i.wdata;
    end
    wrd_q <= work_mem[cmd_i.addr];
  end

  // Load-order copy.
  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_both) begin
      load_mem[cmd_i.laddr] <= cmd_i.wdata;
    end
    lrd_q <= load_mem[cmd_i.laddr];
  end

  assign sts_o.wrd = wrd_q;
  assign sts_o.lrd = lrd_q;

endmodule

// File: rtl/sst_ctrl.sv
// Command sequencer for load, read, searches and selection sort.
module sst_ctrl import sst_pkg::*; (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  output logic                 in_ready_o,
  input  logic [2:0]           in_cmd_i,
  input  logic [AddrBits-1:0]  in_index_i,
  input  logic [ValueBits-1:0] in_value_i,
  input  logic [CountBits-1:0] used_count_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic [1:0]           out_status_o,
  output logic [AddrBits-1:0]  out_position_o,
  output logic [ValueBits-1:0] out_element_o,
  output logic [StepBits-1:0]  out_step_count_o,
  output dp_cmd_t              dp_cmd_o,
  input  dp_sts_t              dp_sts_i
);

  typedef enum logic [8:0] {
    S_IDLE  = 9'b0_0000_0001,
    S_RDW   = 9'b0_0000_0010,  // read issued, wait for data
    S_SCAN  = 9'b0_0000_0100,  // linear search probe evaluate
    S_BIN   = 9'b0_0000_1000,  // binary search probe evaluate
    S_SRDM  = 9'b0_0001_0000,  // sort: evaluate inner probe
    S_SSWA  = 9'b0_0010_0000,  // sort: write min value to s
    S_SSWB  = 9'b0_0100_0000,  // sort: write old s value to m
    S_OUT   = 9'b0_1000_0000,
    S_SNXT  = 9'b1_0000_0000   // sort: issue first read of the next pass
  } state_e;

  state_e state_q, state_d;
  logic [2:0]           cmd_q;
  logic [ValueBits-1:0] key_q;
  logic [CountBits-1:0] n_q;
  logic [CountBits-1:0] i_q, i_d;       // probe index
  logic [CountBits-1:0] s_q, s_d;       // sort outer index
  logic [CountBits-1:0] m_q, m_d;       // sort minimum index
  logic [ValueBits-1:0] mv_q, mv_d;     // sort minimum value
  logic [ValueBits-1:0] sv_q, sv_d;     // value at s
  logic [CountBits:0]   lo_q, lo_d, hi_q, hi_d;  // signed-style bounds, bit 9 sign
  logic [StepBits-1:0]  steps_q, steps_d;
  logic [1:0]           st_q, st_d;
  logic [AddrBits-1:0]  pos_q, pos_d;
  logic [ValueBits-1:0] el_q, el_d;
  logic [CountBits-1:0] n_eff;
  logic [CountBits:0]   mid;
  logic [StepBits-1:0]  steps_inc;

  // Effective count clamps zero to one and large values to the depth.
  always_comb begin
    n_eff = used_count_i;
    if (used_count_i == '0) n_eff = CountBits'(1);
    if (used_count_i > CountBits'(Depth)) n_eff = CountBits'(Depth);
  end

  assign mid       = (lo_q + hi_q) >> 1;
  assign steps_inc = (steps_q == StepMax) ? StepMax : steps_q + 1'b1;
  assign in_ready_o = (state_q == S_IDLE);

  // Sequencer.
  always_comb begin
    state_d = state_q;
    i_d = i_q; s_d = s_q; m_d = m_q; mv_d = mv_q; sv_d = sv_q;
    lo_d = lo_q; hi_d = hi_q; steps_d = steps_q;
    st_d = st_q; pos_d = pos_q; el_d = el_q;
    dp_cmd_o = '0;
    dp_cmd_o.wdata = in_value_i;
    dp_cmd_o.addr  = i_q[AddrBits-1:0];
    dp_cmd_o.laddr = i_q[AddrBits-1:0];
    case (state_q)
      S_IDLE: begin
        dp_cmd_o.addr  = in_index_i;
        dp_cmd_o.laddr = in_index_i;
        if (in_valid_i) begin
          st_d = ST_OK; pos_d = '0; el_d = '0; steps_d = '0;
          i_d = '0;
          case (in_cmd_i)
            CMD_LOAD: begin
              if ({1'b0, in_index_i} >= n_eff) st_d = ST_RANGE;
              else dp_cmd_o.wr_both = 1'b1;
              state_d = S_OUT;
            end
            CMD_READ: begin
              if ({1'b0, in_index_i} >= n_eff) begin
                st_d = ST_RANGE; state_d = S_OUT;
              end else state_d = S_RDW;
            end
            CMD_SLIN, CMD_LLIN: begin
              dp_cmd_o.addr = '0; dp_cmd_o.laddr = '0;
              state_d = S_SCAN;
            end
            CMD_BIN: begin
              lo_d = '0;
              hi_d = {1'b0, n_eff} - 1'b1;
              dp_cmd_o.addr = AddrBits'(({1'b0, n_eff} - 1'b1) >> 1);
              state_d = S_BIN;
            end
            CMD_SORT: begin
              if (n_eff == CountBits'(1)) state_d = S_OUT;
              else begin
                s_d = '0; m_d = '0; i_d = '0;
                dp_cmd_o.addr = '0;
                state_d = S_SRDM;
              end
            end
            default: state_d = S_OUT;
          endcase
        end
      end
      S_RDW: begin
        el_d = dp_sts_i.wrd;
        state_d = S_OUT;
      end
      S_SCAN: begin
        steps_d = steps_inc;
        if (cmd_q == CMD_SLIN ? dp_sts_i.wrd == key_q : dp_sts_i.lrd == key_q) begin
          pos_d = i_q[AddrBits-1:0]; state_d = S_OUT;
        end else if ((cmd_q == CMD_SLIN && dp_sts_i.wrd > key_q) ||
                     i_q + 1'b1 == n_q) begin
          st_d = ST_NOT_FOUND; state_d = S_OUT;
        end else begin
          i_d = i_q + 1'b1;
          dp_cmd_o.addr  = AddrBits'(i_q + 1'b1);
          dp_cmd_o.laddr = AddrBits'(i_q + 1'b1);
        end
      end
      S_BIN: begin
        steps_d = steps_inc;
        if (dp_sts_i.wrd == key_q) begin
          pos_d = mid[AddrBits-1:0]; state_d = S_OUT;
        end else begin
          if (dp_sts_i.wrd < key_q) lo_d = mid + 1'b1;
          else hi_d = mid - 1'b1;
          if ((dp_sts_i.wrd < key_q && mid + 1'b1 > hi_q) ||
              (dp_sts_i.wrd > key_q && (mid == '0 || mid - 1'b1 < lo_q))) begin
            st_d = ST_NOT_FOUND; state_d = S_OUT;
          end else if (dp_sts_i.wrd < key_q) begin
            dp_cmd_o.addr = AddrBits'((mid + 1'b1 + hi_q) >> 1);
          end else begin
            dp_cmd_o.addr = AddrBits'((lo_q + mid - 1'b1) >> 1);
          end
        end
      end
      S_SRDM: begin
        // i_q is the index whose data has just arrived.
        if (i_q == s_q) begin
          mv_d = dp_sts_i.wrd; sv_d = dp_sts_i.wrd; m_d = s_q;
        end else if (dp_sts_i.wrd < mv_q) begin
          mv_d = dp_sts_i.wrd; m_d = i_q; steps_d = steps_inc;
        end
        if (i_q + 1'b1 == n_q) state_d = S_SSWA;
        else begin
          i_d = i_q + 1'b1;
          dp_cmd_o.addr = AddrBits'(i_q + 1'b1);
        end
      end
      S_SSWA: begin
        dp_cmd_o.wr_work = 1'b1;
        dp_cmd_o.addr = s_q[AddrBits-1:0];
        dp_cmd_o.wdata = mv_q;
        state_d = S_SSWB;
      end
      S_SSWB: begin
        dp_cmd_o.wr_work = 1'b1;
        dp_cmd_o.addr = m_q[AddrBits-1:0];
        dp_cmd_o.wdata = sv_q;
        if (s_q + 2'd2 == n_q) state_d = S_OUT;
        else begin
          s_d = s_q + 1'b1; i_d = s_q + 1'b1;
          state_d = S_SNXT;
        end
      end
      // The write port was busy with the swap, so the next pass reads its first entry here.
      S_SNXT: begin
        dp_cmd_o.addr = s_q[AddrBits-1:0];
        state_d = S_SRDM;
      end
      S_OUT: begin
        dp_cmd_o.addr = i_q[AddrBits-1:0];
        if (out_ready_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Working registers.
  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_valid_i) begin
      cmd_q <= in_cmd_i; key_q <= in_value_i; n_q <= n_eff;
    end
    i_q <= i_d; s_q <= s_d; m_q <= m_d; mv_q <= mv_d; sv_q <= sv_d;
    lo_q <= lo_d; hi_q <= hi_d; steps_q <= steps_d;
    st_q <= st_d; pos_q <= pos_d; el_q <= el_d;
  end

  assign out_valid_o      = (state_q == S_OUT);
  assign out_status_o     = st_q;
  assign out_position_o   = pos_q;
  assign out_element_o    = el_q;
  assign out_step_count_o = steps_q;

`ifndef SYNTHESIS
  a_ready_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_ready_o |-> !out_valid_o) else $error("ready while result pending");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");
  a_accept_leaves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o |=> !in_ready_o) else $error("accept did not start work");
`endif

endmodule

// File: rtl/sort_and_search_table.sv
// Top level of the sort and search table.
// Usage: commands arrive as words on the s_axis channel (tdata: cmd[2:0],
// index[10:3], value[20:11]); each gives one result word on m_axis
// (tdata: status[1:0], position[9:2], element[19:10], step_count[34:20]).
// The user must write used_count on the cfg channel only while the block is
// idle; the block itself does not enforce this. One command is worked at a
// time; s_axis_tready is high only when idle. A linear search probes up to
// used_count entries and a binary search up to 9. The sort scans the working
// table through its single port one entry a cycle, and each pass ends with
// the swap writes to s and m and, but for the last pass, a read that restarts
// the scan for the next pass.
// Reset returns the sequencer to idle and used_count to 256; table
// contents are undefined until loaded.
// If the receiver stalls, the result word holds on m_axis and no new
// command is taken until it has been accepted.
module sort_and_search_table import sst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [8:0]  cfg_data_i,      // used_count
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,    // cmd, index, value
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata     // status, position, element, step_count
);

  logic [CountBits-1:0] used_count_q;
  dp_cmd_t dp_cmd;
  dp_sts_t dp_sts;
  logic [1:0]           status;
  logic [AddrBits-1:0]  position;
  logic [ValueBits-1:0] element;
  logic [StepBits-1:0]  step_count;

  // Configuration register.
  assign cfg_ready_o = 1'b1;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      used_count_q <= CountBits'(Depth);
    end else if (cfg_valid_i) begin
      used_count_q <= cfg_data_i;
    end
  end

  sst_ctrl u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(s_axis_tvalid), .in_ready_o(s_axis_tready),
    .in_cmd_i(s_axis_tdata[2:0]), .in_index_i(s_axis_tdata[10:3]),
    .in_value_i(s_axis_tdata[20:11]), .used_count_i(used_count_q),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .out_status_o(status), .out_position_o(position),
    .out_element_o(element), .out_step_count_o(step_count),
    .dp_cmd_o(dp_cmd), .dp_sts_i(dp_sts)
  );

  sst_datapath u_dp (.clk_i, .cmd_i(dp_cmd), .sts_o(dp_sts));

  assign m_axis_tdata = {5'd0, step_count, element, position, status};

endmodule

// File: sim/sst_checker.sv
// Checker for the sort and search table: it predicts each result word and compares it.
`timescale 1ns / 1ps

module sst_checker import sst_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [8:0]  cfg_data_i,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [23:0] s_tdata_i,    // cmd, index, value
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [39:0] m_tdata_i,    // status, position, element, step_count
  output int          err_count_o,
  output int          pending_o
);

  // Members run from the highest bits down, so status lands in the lowest bits.
  typedef struct packed {
    logic [StepBits-1:0] step_count;
    logic [ValueBits-1:0] element;
    logic [AddrBits-1:0] position;
    logic [1:0]          status;
  } table_res_t;

  logic [ValueBits-1:0] work_tbl [Depth];
  logic [ValueBits-1:0] load_tbl [Depth];
  logic [8:0]           used_count;
  table_res_t           expected_q [$];

  // Works out the result of one command and updates the model tables.
  function automatic table_res_t compute_result(input logic [2:0] c,
                                                input logic [7:0] idx,
                                                input logic [9:0] key);
    table_res_t r;
    int n, steps, lo, hi, mid, m;
    logic [ValueBits-1:0] t;
    bit done;
    r = '0;
    r.status = ST_OK;
    n = used_count;
    if (n < 1) n = 1;
    if (n > Depth) n = Depth;
    steps = 0;
    done = 0;
    case (c)
      CMD_LOAD: begin
        if (idx >= n) r.status = ST_RANGE;
        else begin
          work_tbl[idx] = key;
          load_tbl[idx] = key;
        end
      end
      CMD_SORT: begin
        for (int s = 0; s + 1 < n; s++) begin
          m = s;
          for (int i = s + 1; i < n; i++) begin
            if (work_tbl[i] < work_tbl[m]) begin
              steps++;
              m = i;
            end
          end
          t = work_tbl[s];
          work_tbl[s] = work_tbl[m];
          work_tbl[m] = t;
        end
      end
      CMD_SLIN: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < n && !done; i++) begin
          steps++;
          if (work_tbl[i] > key) done = 1;
          else if (work_tbl[i] == key) begin
            r.status = ST_OK;
            r.position = i[7:0];
            done = 1;
          end
        end
      end
      CMD_LLIN: begin
        r.status = ST_NOT_FOUND;
        for (int i = 0; i < n && !done; i++) begin
          steps++;
          if (load_tbl[i] == key) begin
            r.status = ST_OK;
            r.position = i[7:0];
            done = 1;
          end
        end
      end
      CMD_BIN: begin
        r.status = ST_NOT_FOUND;
        lo = 0;
        hi = n - 1;
        while (lo <= hi && !done) begin
          mid = (lo + hi) / 2;
          steps++;
          if (work_tbl[mid] == key) begin
            r.status = ST_OK;
            r.position = mid[7:0];
            done = 1;
          end else if (work_tbl[mid] < key) lo = mid + 1;
          else hi = mid - 1;
        end
      end
      CMD_READ: begin
        if (idx >= n) r.status = ST_RANGE;
        else r.element = work_tbl[idx];
      end
      default: ;
    endcase
    r.step_count = (steps > 32767) ? StepMax : steps[14:0];
    return r;
  endfunction

  // Watch the three channels: configuration, commands in and results out.
  always @(posedge clk_i or negedge rst_ni) begin
    table_res_t got, exp_r;
    if (!rst_ni) begin
      used_count  <= 9'd256;
      expected_q.delete();
      err_count_o <= 0;
      pending_o   <= 0;
      for (int i = 0; i < Depth; i++) begin
        work_tbl[i] = '0;
        load_tbl[i] = '0;
      end
    end else begin
      if (cfg_valid_i && cfg_ready_i) used_count <= cfg_data_i;
      if (m_tvalid_i && m_tready_i) begin
        got = m_tdata_i[34:0];
        if (expected_q.size() == 0) begin
          $error("result word with no command waiting: %h", m_tdata_i);
          err_count_o <= err_count_o + 1;
        end else begin
          exp_r = expected_q.pop_front();
          if (got !== exp_r) err_count_o <= err_count_o + 1;
          if (got.status !== exp_r.status)
            $error("status: expected %0d, got %0d", exp_r.status, got.status);
          if (got.position !== exp_r.position)
            $error("position: expected %0d, got %0d", exp_r.position, got.position);
          if (got.element !== exp_r.element)
            $error("element: expected %0d, got %0d", exp_r.element, got.element);
          if (got.step_count !== exp_r.step_count)
            $error("step_count: expected %0d, got %0d", exp_r.step_count,
                   got.step_count);
        end
      end
      if (s_tvalid_i && s_tready_i)
        expected_q.push_back(compute_result(s_tdata_i[2:0], s_tdata_i[10:3],
                                            s_tdata_i[20:11]));
      pending_o <= expected_q.size();
    end
  end

endmodule

// File: sim/sort_and_search_table_tb.sv
// Testbench top for the sort and search table: stimulus, receiver stalls and verdict.
`timescale 1ns / 1ps

module sort_and_search_table_tb;
  import sst_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [8:0]  cfg_data = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [23:0] s_axis_tdata = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [39:0] m_axis_tdata;
  int          err_count, pending;

  int          words_sent = 0;
  int          cfg_writes = 0;
  int          big_phases = 0;
  int          burst_left = 0;
  int          stall_cycle = 0;
  int          stall_mode = 0;
  int          used_n = 256;
  bit          written [Depth];

  sort_and_search_table u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid),
    .cfg_ready_o   (cfg_ready),
    .cfg_data_i    (cfg_data),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  sst_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid),
    .cfg_ready_i (cfg_ready),
    .cfg_data_i  (cfg_data),
    .s_tvalid_i  (s_axis_tvalid),
    .s_tready_i  (s_axis_tready),
    .s_tdata_i   (s_axis_tdata),
    .m_tvalid_i  (m_axis_tvalid),
    .m_tready_i  (m_axis_tready),
    .m_tdata_i   (m_axis_tdata),
    .err_count_o (err_count),
    .pending_o   (pending)
  );

  initial begin
    forever #2 clk_i = ~clk_i;
  end

  // Receiver stalls: the stall pattern is picked at random and changed periodically.
  always @(posedge clk_i) begin
    stall_cycle <= stall_cycle + 1;
    if (stall_cycle % 300 == 0) stall_mode <= $urandom_range(0, 3);
    case (stall_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) == 1);
      2: m_axis_tready <= ($urandom_range(0, 3) == 0);
      default: m_axis_tready <= (stall_cycle % 7) < 4;
    endcase
  end

  // Sends one command word, with bursts and random gaps before it.
  task automatic send_word(input logic [2:0] c, input logic [7:0] idx,
                           input logic [9:0] v);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 12);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {3'b000, v, idx, c};
    do @(posedge clk_i); while (!s_axis_tready);
    words_sent++;
    if (c == CMD_LOAD && idx < used_n) written[idx] = 1'b1;
  endtask

  // Writes used_count once the block has returned every result.
  task automatic write_count(input logic [8:0] cnt);
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
    cfg_valid <= 1'b1;
    cfg_data  <= cnt;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
    cfg_writes++;
    used_n = (cnt < 1) ? 1 : (cnt > Depth) ? Depth : cnt;
  endtask

  // Key that is usually present in the table, sometimes not.
  function automatic logic [9:0] pick_key();
    if ($urandom_range(0, 2) != 0) return u_checker.load_tbl[$urandom_range(0, used_n - 1)];
    return 10'($urandom_range(0, 1023));
  endfunction

  initial begin
    int n_items, ops;
    logic [8:0] cnt;
    logic [2:0] c;
    logic [7:0] idx;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset count, extremes, each command and the odd cases.
    send_word(CMD_LOAD, 8'd255, 10'd1023);
    send_word(CMD_READ, 8'd255, 10'd0);
    write_count(9'd4);
    send_word(CMD_LOAD, 8'd0, 10'd1023);
    send_word(CMD_LOAD, 8'd1, 10'd0);
    send_word(CMD_LOAD, 8'd2, 10'd512);
    send_word(CMD_LOAD, 8'd3, 10'd5);
    send_word(CMD_LOAD, 8'd200, 10'd7);
    send_word(CMD_READ, 8'd7, 10'd0);
    send_word(CMD_SLIN, 8'd0, 10'd512);
    send_word(CMD_LLIN, 8'd0, 10'd5);
    send_word(CMD_LLIN, 8'd0, 10'd333);
    send_word(CMD_SORT, 8'd0, 10'd0);
    send_word(CMD_READ, 8'd3, 10'd0);
    send_word(CMD_SLIN, 8'd0, 10'd6);
    send_word(CMD_SLIN, 8'd0, 10'd1023);
    send_word(CMD_BIN, 8'd0, 10'd0);
    send_word(CMD_BIN, 8'd0, 10'd1023);
    send_word(CMD_BIN, 8'd0, 10'd700);
    send_word(3'd6, 8'hAA, 10'h155);
    send_word(3'd7, 8'h55, 10'h2AA);
    write_count(9'd0);
    send_word(CMD_BIN, 8'd0, 10'd0);
    send_word(CMD_READ, 8'd1, 10'd0);

    // Random phases: a new count, fill the table, then a random command mix.
    while (words_sent < 900) begin
      if (big_phases < 2 && $urandom_range(0, 9) == 0) begin
        cnt = (big_phases == 0) ? 9'd511 : 9'($urandom_range(200, 300));
        big_phases++;
        ops = 12;
      end else begin
        cnt = 9'($urandom_range(1, 24));
        ops = $urandom_range(20, 40);
      end
      write_count(cnt);
      for (int i = 0; i < used_n; i++)
        if (!written[i] || $urandom_range(0, 3) == 0)
          send_word(CMD_LOAD, i[7:0], ($urandom_range(0, 1) == 1) ?
                    10'($urandom_range(0, 15)) : 10'($urandom_range(0, 1023)));
      for (int k = 0; k < ops; k++) begin
        n_items = $urandom_range(0, 99);
        idx = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255)) :
              8'($urandom_range(0, used_n - 1));
        if (n_items < 20) c = CMD_LOAD;
        else if (n_items < 28) c = (used_n > 64 && k % 6 != 0) ? CMD_READ : CMD_SORT;
        else if (n_items < 45) c = CMD_SLIN;
        else if (n_items < 62) c = CMD_LLIN;
        else if (n_items < 80) c = CMD_BIN;
        else if (n_items < 97) c = CMD_READ;
        else c = 3'($urandom_range(6, 7));
        if (c == CMD_LOAD)
          send_word(c, idx, 10'($urandom_range(0, 1023)));
        else
          send_word(c, idx, pick_key());
      end
    end

    // Drain the remaining results.
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
    $display("Run covered %0d command words over %0d table sizes,", words_sent, cfg_writes);
    $display("including %0d large-table phases with full sorts.", big_phases);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #20ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule

// File: filelist.f
rtl/sst_pkg.sv
rtl/sst_datapath.sv
rtl/sst_ctrl.sv
rtl/sort_and_search_table.sv
sim/sst_checker.sv
sim/sort_and_search_table_tb.sv
